### design/lsrs_pkg.sv
// shared types and constants for the laser scan range segmenter
package lsrs_pkg;

    localparam int RANGE_W    = 16;
    localparam int IDX_OUT_W  = 9;
    localparam int CNT_OUT_W  = 10;
    localparam int MIN_PTS_W  = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_SLOTS  = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_BREAK_THRESHOLD    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SEGMENT_POINTS = 1'd1;

    localparam logic [RANGE_W-1:0]   BREAK_THRESHOLD_RST    = 16'd100;
    localparam logic [MIN_PTS_W-1:0] MIN_SEGMENT_POINTS_RST = 11'd4;

    // record slots of one sample, in delivery order
    localparam int SLOT_CLOSED = 0;
    localparam int SLOT_HELD   = 1;
    localparam int SLOT_FINAL  = 2;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] first_index;
        logic [IDX_OUT_W-1:0] final_index;
        logic [CNT_OUT_W-1:0] point_count;
        logic                 wraps_around;
    } t_seg_rec;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]           valid;
        t_seg_rec [NUM_SLOTS-1:0]       rec;
    } t_seg_bundle;

endpackage

### design/lsrs_front.sv
// front end: sample acceptance, breakpoint detection and record building
module lsrs_front #(
    parameter int MAX_SAMPLES = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lsrs_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [lsrs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_accept,
    input  logic [lsrs_pkg::RANGE_W-1:0]      i_range_mm,
    input  logic                              i_scan_end,
    output lsrs_pkg::t_seg_bundle             o_bundle
);

    localparam int IW    = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (CW > lsrs_pkg::MIN_PTS_W) ? CW : lsrs_pkg::MIN_PTS_W;

    logic [lsrs_pkg::RANGE_W-1:0]   r_break_threshold;
    logic [lsrs_pkg::MIN_PTS_W-1:0] r_min_points;

    logic [IW-1:0]                r_sample_index;
    logic [lsrs_pkg::RANGE_W-1:0] r_previous_range;
    logic [lsrs_pkg::RANGE_W-1:0] r_scan_first_range;
    logic [IW-1:0]                r_segment_start;
    logic [CW-1:0]                r_segment_count;
    logic [IW-1:0]                r_held_end;
    logic [CW-1:0]                r_held_count;
    logic                         r_held_valid;

    logic [IW-1:0]                n_sample_index;
    logic [lsrs_pkg::RANGE_W-1:0] n_scan_first_range;
    logic [IW-1:0]                n_segment_start;
    logic [CW-1:0]                n_segment_count;
    logic [IW-1:0]                n_held_end;
    logic [CW-1:0]                n_held_count;
    logic                         n_held_valid;

    logic [lsrs_pkg::RANGE_W-1:0] w_diff_prev;
    logic [lsrs_pkg::RANGE_W-1:0] w_diff_first;
    logic                         w_near_prev;
    logic                         w_near_first;
    logic                         w_last;
    logic                         w_keep;
    logic [CW-1:0]                w_end;
    logic [CW:0]                  w_merge_count;
    logic                         w_merge;

    always_comb begin
        w_diff_prev  = (i_range_mm >= r_previous_range) ? i_range_mm - r_previous_range
                                                        : r_previous_range - i_range_mm;
        w_diff_first = (i_range_mm >= r_scan_first_range) ? i_range_mm - r_scan_first_range
                                                          : r_scan_first_range - i_range_mm;
        w_near_prev  = (w_diff_prev <= r_break_threshold);
        w_near_first = (w_diff_first <= r_break_threshold);
        w_last       = i_scan_end || (r_sample_index == IW'(MAX_SAMPLES - 1));
        w_keep       = (CMP_W'(r_segment_count) >= CMP_W'(r_min_points));
        w_end        = CW'(r_segment_start) + r_segment_count - CW'(1);

        n_scan_first_range = r_scan_first_range;
        n_segment_start    = r_segment_start;
        n_segment_count    = r_segment_count;
        n_held_end         = r_held_end;
        n_held_count       = r_held_count;
        n_held_valid       = r_held_valid;
        o_bundle           = '0;

        if (r_sample_index == '0) begin
            n_scan_first_range = i_range_mm;
            n_segment_start    = '0;
            n_segment_count    = CW'(1);
            n_held_valid       = 1'b0;
        end else if (w_near_prev) begin
            n_segment_count = r_segment_count + CW'(1);
        end else begin
            if (w_keep) begin
                if (r_segment_start == '0) begin
                    n_held_end   = IW'(w_end);
                    n_held_count = r_segment_count;
                    n_held_valid = 1'b1;
                end else begin
                    o_bundle.valid[lsrs_pkg::SLOT_CLOSED] = 1'b1;
                    o_bundle.rec[lsrs_pkg::SLOT_CLOSED].first_index =
                        lsrs_pkg::IDX_OUT_W'(r_segment_start);
                    o_bundle.rec[lsrs_pkg::SLOT_CLOSED].final_index =
                        lsrs_pkg::IDX_OUT_W'(w_end);
                    o_bundle.rec[lsrs_pkg::SLOT_CLOSED].point_count =
                        lsrs_pkg::CNT_OUT_W'(r_segment_count);
                end
            end
            n_segment_start = r_sample_index;
            n_segment_count = CW'(1);
        end

        w_merge_count = (CW+1)'(n_segment_count) + (CW+1)'(n_held_count);
        w_merge       = n_held_valid && (n_segment_start != '0) && w_near_first;

        if (w_last) begin
            o_bundle.valid[lsrs_pkg::SLOT_FINAL] = 1'b1;
            o_bundle.rec[lsrs_pkg::SLOT_FINAL].first_index =
                lsrs_pkg::IDX_OUT_W'(n_segment_start);
            if (w_merge) begin
                o_bundle.rec[lsrs_pkg::SLOT_FINAL].final_index =
                    lsrs_pkg::IDX_OUT_W'(n_held_end);
                o_bundle.rec[lsrs_pkg::SLOT_FINAL].point_count =
                    lsrs_pkg::CNT_OUT_W'(w_merge_count);
                o_bundle.rec[lsrs_pkg::SLOT_FINAL].wraps_around = 1'b1;
            end else begin
                o_bundle.rec[lsrs_pkg::SLOT_FINAL].final_index =
                    lsrs_pkg::IDX_OUT_W'(r_sample_index);
                o_bundle.rec[lsrs_pkg::SLOT_FINAL].point_count =
                    lsrs_pkg::CNT_OUT_W'(n_segment_count);
                if (n_held_valid) begin
                    o_bundle.valid[lsrs_pkg::SLOT_HELD] = 1'b1;
                    o_bundle.rec[lsrs_pkg::SLOT_HELD].final_index =
                        lsrs_pkg::IDX_OUT_W'(n_held_end);
                    o_bundle.rec[lsrs_pkg::SLOT_HELD].point_count =
                        lsrs_pkg::CNT_OUT_W'(n_held_count);
                end
            end
            n_sample_index = '0;
            n_held_valid   = 1'b0;
        end else begin
            n_sample_index = r_sample_index + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_threshold <= lsrs_pkg::BREAK_THRESHOLD_RST;
            r_min_points      <= lsrs_pkg::MIN_SEGMENT_POINTS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == lsrs_pkg::REG_BREAK_THRESHOLD) begin
                r_break_threshold <= i_cfg_wdata;
            end else if (i_cfg_addr == lsrs_pkg::REG_MIN_SEGMENT_POINTS) begin
                r_min_points <= i_cfg_wdata[lsrs_pkg::MIN_PTS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index     <= '0;
            r_previous_range   <= '0;
            r_scan_first_range <= '0;
            r_segment_start    <= '0;
            r_segment_count    <= '0;
            r_held_end         <= '0;
            r_held_count       <= '0;
            r_held_valid       <= 1'b0;
        end else if (i_accept) begin
            r_sample_index     <= n_sample_index;
            r_previous_range   <= i_range_mm;
            r_scan_first_range <= n_scan_first_range;
            r_segment_start    <= n_segment_start;
            r_segment_count    <= n_segment_count;
            r_held_end         <= n_held_end;
            r_held_count       <= n_held_count;
            r_held_valid       <= n_held_valid;
        end
    end

endmodule

### design/lsrs_queue.sv
// two-entry queue of record bundles between front and back
module lsrs_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lsrs_pkg::t_seg_bundle i_bundle,
    input  logic                  i_pop,
    output lsrs_pkg::t_seg_bundle o_head,
    output logic                  o_valid,
    output logic                  o_full
);

    logic [1:0]            r_count;
    lsrs_pkg::t_seg_bundle r_ent0;
    lsrs_pkg::t_seg_bundle r_ent1;

    assign o_head  = r_ent0;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_push && !i_pop) begin
            r_count <= r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (i_push && r_count == 2'd1) begin
                r_ent0 <= i_bundle;
            end else begin
                r_ent0 <= r_ent1;
            end
            if (i_push && r_count == 2'd2) begin
                r_ent1 <= i_bundle;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_ent0 <= i_bundle;
            end else begin
                r_ent1 <= i_bundle;
            end
        end
    end

endmodule

### design/lsrs_back.sv
// back end: delivers the records of a bundle one beat at a time
module lsrs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsrs_pkg::t_seg_bundle         i_head,
    input  logic                          i_head_valid,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lsrs_pkg::IDX_OUT_W-1:0] o_first_index,
    output logic [lsrs_pkg::IDX_OUT_W-1:0] o_final_index,
    output logic [lsrs_pkg::CNT_OUT_W-1:0] o_point_count,
    output logic                          o_wraps_around,
    output logic                          o_run_last
);

    logic [lsrs_pkg::NUM_SLOTS-1:0] r_done;
    logic [lsrs_pkg::NUM_SLOTS-1:0] w_pending;
    logic [1:0]                     w_sel;
    logic                           w_last;
    logic                           w_beat;
    lsrs_pkg::t_seg_rec             w_rec;

    always_comb begin
        w_pending = i_head.valid & ~r_done;
        if (w_pending[lsrs_pkg::SLOT_CLOSED]) begin
            w_sel  = 2'(lsrs_pkg::SLOT_CLOSED);
            w_last = !(w_pending[lsrs_pkg::SLOT_HELD] || w_pending[lsrs_pkg::SLOT_FINAL]);
        end else if (w_pending[lsrs_pkg::SLOT_HELD]) begin
            w_sel  = 2'(lsrs_pkg::SLOT_HELD);
            w_last = !w_pending[lsrs_pkg::SLOT_FINAL];
        end else begin
            w_sel  = 2'(lsrs_pkg::SLOT_FINAL);
            w_last = 1'b1;
        end
        w_rec  = i_head.rec[w_sel];
        w_beat = i_head_valid && i_ready;
    end

    assign o_valid        = i_head_valid;
    assign o_first_index  = w_rec.first_index;
    assign o_final_index  = w_rec.final_index;
    assign o_point_count  = w_rec.point_count;
    assign o_wraps_around = w_rec.wraps_around;
    assign o_run_last     = w_last;
    assign o_pop          = w_beat && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (w_beat) begin
            if (w_last) begin
                r_done <= '0;
            end else begin
                r_done[w_sel] <= 1'b1;
            end
        end
    end

endmodule

### design/laser_scan_range_segmenter.sv
// laser scan range segmenter top level
// takes one range sample per cycle while the two-entry bundle queue has room
// records of a sample are registered into the bundle queue on its acceptance, then leave it one record per beat
// a sample causes up to three records; the output port drains one per cycle while i_ready is high
// synchronous reset clears scan state and queue and restores register defaults
module laser_scan_range_segmenter #(
    parameter int MAX_SAMPLES = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lsrs_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [lsrs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [lsrs_pkg::RANGE_W-1:0]      i_range_mm,
    input  logic                              i_scan_end,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [lsrs_pkg::IDX_OUT_W-1:0]    o_first_index,
    output logic [lsrs_pkg::IDX_OUT_W-1:0]    o_final_index,
    output logic [lsrs_pkg::CNT_OUT_W-1:0]    o_point_count,
    output logic                              o_wraps_around,
    output logic                              o_run_last
);

    logic                  w_accept;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_q_valid;
    logic                  w_q_full;
    lsrs_pkg::t_seg_bundle w_bundle;
    lsrs_pkg::t_seg_bundle w_q_head;

    assign o_ready  = !w_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_push   = w_accept && (w_bundle.valid != '0);

    lsrs_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_accept   (w_accept),
        .i_range_mm (i_range_mm),
        .i_scan_end (i_scan_end),
        .o_bundle   (w_bundle)
    );

    lsrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_bundle(w_bundle),
        .i_pop   (w_pop),
        .o_head  (w_q_head),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    lsrs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_q_head),
        .i_head_valid  (w_q_valid),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_first_index (o_first_index),
        .o_final_index (o_final_index),
        .o_point_count (o_point_count),
        .o_wraps_around(o_wraps_around),
        .o_run_last    (o_run_last)
    );

    a_last_beat_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_run_last) |-> w_pop)
        else $error("last record beat did not release its bundle");

    a_queued_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid |-> (w_q_head.valid != '0))
        else $error("queued bundle holds no record");

    a_wrap_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_wraps_around) |-> o_run_last)
        else $error("wrapped record is not the last of its sample");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_full && !w_pop) |=> w_q_full)
        else $error("full queue drained without a pop");

endmodule

### test/laser_scan_range_segmenter_tb.sv
`timescale 1ns / 100ps
// testbench for the laser scan range segmenter: directed and random scans against predicted records
module laser_scan_range_segmenter_tb;

    localparam int SCAN_LIMIT  = 512;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 27;
    localparam int PHASE_ITEMS = 28;

    typedef struct packed {
        lsrs_pkg::t_seg_rec rec;
        logic               run_last;
    } t_seg_due;

    class segment_tracker;
        logic [lsrs_pkg::RANGE_W-1:0]   gap_limit;
        logic [lsrs_pkg::MIN_PTS_W-1:0] keep_min;
        logic [8:0]                     beam;
        logic [lsrs_pkg::RANGE_W-1:0]   prev_range;
        logic [lsrs_pkg::RANGE_W-1:0]   scan_first;
        logic [8:0]                     seg_first;
        logic [9:0]                     seg_points;
        logic [8:0]                     held_last;
        logic [9:0]                     held_points;
        logic                           held_ok;
        t_seg_due                       due_segments[$];
        int                             errors;
        int                             beat_no;

        function new();
            gap_limit   = lsrs_pkg::BREAK_THRESHOLD_RST;
            keep_min    = lsrs_pkg::MIN_SEGMENT_POINTS_RST;
            beam        = '0;
            prev_range  = '0;
            scan_first  = '0;
            seg_first   = '0;
            seg_points  = '0;
            held_last   = '0;
            held_points = '0;
            held_ok     = 1'b0;
            errors      = 0;
            beat_no     = 0;
        endfunction

        function int pending();
            return due_segments.size();
        endfunction

        function int unsigned range_gap(logic [lsrs_pkg::RANGE_W-1:0] a,
                                        logic [lsrs_pkg::RANGE_W-1:0] b);
            return (a >= b) ? a - b : b - a;
        endfunction

        function void add_segment(logic [8:0] first_idx, logic [8:0] last_idx, int points,
                                  logic wraps);
            t_seg_due d;
            d.rec.first_index  = first_idx;
            d.rec.final_index  = last_idx;
            d.rec.point_count  = 10'(points);
            d.rec.wraps_around = wraps;
            d.run_last         = 1'b0;
            due_segments.insert(due_segments.size(), d);
        endfunction

        function void take_config(logic [lsrs_pkg::CFG_ADDR_W-1:0] addr,
                                  logic [lsrs_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                lsrs_pkg::REG_BREAK_THRESHOLD: begin
                    gap_limit = data;
                end
                lsrs_pkg::REG_MIN_SEGMENT_POINTS: begin
                    keep_min = data[lsrs_pkg::MIN_PTS_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void take_sample(logic [lsrs_pkg::RANGE_W-1:0] r, logic scan_end);
            int   before_n;
            logic is_last;
            before_n = due_segments.size();
            is_last  = scan_end || (beam == 9'(SCAN_LIMIT - 1));
            if (beam == 0) begin
                scan_first = r;
                seg_first  = '0;
                seg_points = 10'd1;
                held_ok    = 1'b0;
            end else if (range_gap(r, prev_range) <= gap_limit) begin
                seg_points++;
            end else begin
                if (int'(seg_points) >= int'(keep_min)) begin
                    if (seg_first == 0) begin
                        held_last   = 9'(int'(seg_first) + int'(seg_points) - 1);
                        held_points = seg_points;
                        held_ok     = 1'b1;
                    end else begin
                        add_segment(seg_first, 9'(int'(seg_first) + int'(seg_points) - 1),
                                    int'(seg_points), 1'b0);
                    end
                end
                seg_first  = beam;
                seg_points = 10'd1;
            end
            prev_range = r;
            if (is_last) begin
                if (held_ok && seg_first != 0 && range_gap(scan_first, r) <= gap_limit) begin
                    add_segment(seg_first, held_last, int'(seg_points) + int'(held_points), 1'b1);
                end else begin
                    if (held_ok) add_segment('0, held_last, int'(held_points), 1'b0);
                    add_segment(seg_first, beam, int'(seg_points), 1'b0);
                end
                beam    = '0;
                held_ok = 1'b0;
            end else begin
                beam++;
            end
            if (due_segments.size() > before_n)
                due_segments[due_segments.size() - 1].run_last = 1'b1;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("mismatch at record %0d: %s", beat_no, what);
        endtask

        task match_segment(lsrs_pkg::t_seg_rec got, logic got_last);
            t_seg_due want;
            beat_no++;
            if (due_segments.size() == 0) begin
                report($sformatf("record %0d..%0d count %0d with nothing outstanding",
                                 got.first_index, got.final_index, got.point_count));
                return;
            end
            want = due_segments.pop_front();
            if (got.first_index !== want.rec.first_index)
                report($sformatf("first_index %0d, want %0d", got.first_index,
                                 want.rec.first_index));
            if (got.final_index !== want.rec.final_index)
                report($sformatf("final_index %0d, want %0d", got.final_index,
                                 want.rec.final_index));
            if (got.point_count !== want.rec.point_count)
                report($sformatf("point_count %0d, want %0d", got.point_count,
                                 want.rec.point_count));
            if (got.wraps_around !== want.rec.wraps_around)
                report($sformatf("wraps_around %b, want %b", got.wraps_around,
                                 want.rec.wraps_around));
            if (got_last !== want.run_last)
                report($sformatf("run_last %b, want %b", got_last, want.run_last));
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [lsrs_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [lsrs_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                            i_valid;
    logic                            o_ready;
    logic [lsrs_pkg::RANGE_W-1:0]    i_range_mm;
    logic                            i_scan_end;
    logic                            o_valid;
    logic                            i_ready;
    logic [lsrs_pkg::IDX_OUT_W-1:0]  o_first_index;
    logic [lsrs_pkg::IDX_OUT_W-1:0]  o_final_index;
    logic [lsrs_pkg::CNT_OUT_W-1:0]  o_point_count;
    logic                            o_wraps_around;
    logic                            o_run_last;

    segment_tracker tracker = new();
    bit             quiet   = 1'b0;
    int             cur_thr = int'(lsrs_pkg::BREAK_THRESHOLD_RST);
    int             cycle_count;

    laser_scan_range_segmenter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_range_mm     (i_range_mm),
        .i_scan_end     (i_scan_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_first_index  (o_first_index),
        .o_final_index  (o_final_index),
        .o_point_count  (o_point_count),
        .o_wraps_around (o_wraps_around),
        .o_run_last     (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic push_sample(logic [lsrs_pkg::RANGE_W-1:0] r, logic scan_end);
        if (!quiet) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid    <= 1'b1;
        i_range_mm <= r;
        i_scan_end <= scan_end;
        do @(posedge i_clk); while (!o_ready);
        tracker.take_sample(r, scan_end);
    endtask

    task automatic send_run(logic [lsrs_pkg::RANGE_W-1:0] r, int n, logic closes);
        for (int i = 0; i < n; i++) push_sample(r, closes && (i == n - 1));
    endtask

    function automatic int pick_step();
        int mag;
        case ($urandom_range(0, 5))
            0: mag = 0;
            1: mag = cur_thr;
            2: mag = cur_thr + 1;
            default: mag = $urandom_range(0, cur_thr);
        endcase
        return ($urandom_range(0, 1) == 1) ? mag : -mag;
    endfunction

    task automatic send_scan(int len, bit tidy);
        int r;
        int first_r;
        first_r = $urandom_range(0, 65535);
        r = first_r;
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                if (!tidy || $urandom_range(0, 99) < 15) begin
                    r = $urandom_range(0, 65535);
                end else if (i == len - 1 && $urandom_range(0, 1) == 1) begin
                    r = first_r + pick_step();
                end else begin
                    r = r + pick_step();
                end
                if (r < 0) r = 0;
                else if (r > 65535) r = 65535;
            end
            push_sample(16'(r), i == len - 1);
        end
    endtask

    task automatic random_phase(int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 24);
            send_scan(len, $urandom_range(0, 9) != 0);
            sent += len;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [lsrs_pkg::CFG_DATA_W-1:0] thr,
                                 logic [lsrs_pkg::CFG_DATA_W-1:0] min_pts);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= lsrs_pkg::REG_BREAK_THRESHOLD;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        tracker.take_config(lsrs_pkg::REG_BREAK_THRESHOLD, thr);
        i_cfg_addr  <= lsrs_pkg::REG_MIN_SEGMENT_POINTS;
        i_cfg_wdata <= min_pts;
        @(posedge i_clk);
        tracker.take_config(lsrs_pkg::REG_MIN_SEGMENT_POINTS, min_pts);
        i_cfg_we <= 1'b0;
        cur_thr = int'(thr);
    endtask

    // result side
    initial begin
        lsrs_pkg::t_seg_rec got;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_ready && o_valid) begin
                got.first_index  = o_first_index;
                got.final_index  = o_final_index;
                got.point_count  = o_point_count;
                got.wraps_around = o_wraps_around;
                tracker.match_segment(got, o_run_last);
            end
            i_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("laser_scan_range_segmenter verification failed");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;
        i_valid     <= 1'b0;
        i_range_mm  <= '0;
        i_scan_end  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-sample scan
        push_sample(16'hFFFF, 1'b1);
        // held start segment, kept middle, short dropped run, wrap merge at scan end
        send_run(16'd1000, 5, 1'b0);
        send_run(16'd5000, 4, 1'b0);
        send_run(16'd9000, 2, 1'b0);
        push_sample(16'd1050, 1'b0);
        push_sample(16'd1020, 1'b1);
        // closed, held and final segment from a single sample
        send_run(16'd0, 4, 1'b0);
        send_run(16'd500, 4, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        // whole scan one segment, steps exactly at the threshold
        push_sample(16'd200, 1'b0);
        push_sample(16'd300, 1'b0);
        push_sample(16'd200, 1'b1);

        // zero minimum keeps every closed segment
        apply_setting(16'd0, 16'd0);
        random_phase(PHASE_ITEMS);

        apply_setting(16'hFFFF, 16'd1024);
        random_phase(PHASE_ITEMS);

        apply_setting(16'd250, 16'd2);
        quiet = 1'b1;
        random_phase(PHASE_ITEMS + 20);
        quiet = 1'b0;

        apply_setting(16'd1500, 16'd1);
        random_phase(PHASE_ITEMS);

        apply_setting(16'($urandom_range(0, 4000)), 16'($urandom_range(1, 6)));
        random_phase(PHASE_ITEMS);

        drain();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("laser_scan_range_segmenter verification clean");
        end else begin
            $display("laser_scan_range_segmenter verification failed");
        end
        $finish;
    end

endmodule
